FILE: rtl/quaternion_multiply_normalize_top_defines.svh
// Assertion macros for the quaternion normalizer top level.
`ifndef QUATERNION_MULTIPLY_NORMALIZE_TOP_DEFINES_SVH
`define QUATERNION_MULTIPLY_NORMALIZE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define QMN_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qmn assertion failed");
`define QMN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qmn assertion failed");
`else
`define QMN_ASSERT_NOW(label, clk, rst, ante, cons)
`define QMN_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/qmn_pkg.sv
// Types and constants of the quaternion multiply and normalize block.
package qmn_pkg;
  localparam int CompW    = 16;   // Q1.15 component
  localparam int ProdW    = 32;   // one partial product
  localparam int PW       = 34;   // Hamilton product component, signed
  localparam int MagW     = 33;   // magnitude of a product component
  localparam int SW       = 65;   // sum of squares, up to 2^64
  localparam int RootW    = 33;   // floor(sqrt(S)), up to 2^32
  localparam int RemW     = 34;   // square root remainder
  localparam int QW       = 16;   // quotient bits
  localparam int FracBits = 15;
  localparam int DivW     = MagW + FracBits;
  localparam int SqStages  = (SW + 1) / 2;
  localparam int DivStages = QW;
  localparam int FrontStages = 6;
  localparam int Latency = FrontStages + SqStages + DivStages + 1;

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic [MagW-1:0]  mag_t;
  typedef logic [RootW-1:0] root_t;
  typedef logic [QW-1:0]    quot_t;
endpackage

FILE: rtl/qmn_ifs.sv
// Valid/ready channel interfaces for operand and result items.
interface qmn_in_if;
  import qmn_pkg::*;
  logic  valid;
  logic  ready;
  comp_t a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z;
  modport source(output valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, input ready);
  modport sink(input valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, output ready);
endinterface

interface qmn_out_if;
  import qmn_pkg::*;
  logic  valid;
  logic  ready;
  comp_t out_w, out_x, out_y, out_z;
  logic  clipped;
  modport source(output valid, out_w, out_x, out_y, out_z, clipped, input ready);
  modport sink(input valid, out_w, out_x, out_y, out_z, clipped, output ready);
endinterface

FILE: rtl/qmn_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module qmn_isqrt (
  input  logic                     clk,
  input  logic                     en,
  input  logic [qmn_pkg::SW-1:0]   s,
  output logic [qmn_pkg::RootW-1:0] root
);
  import qmn_pkg::*;

  logic [SW-1:0]    s_r  [SqStages];
  logic [RootW-1:0] rt_r [SqStages];
  logic [RemW-1:0]  rm_r [SqStages];

  for (genvar i = 0; i < SqStages; i++) begin : g_stage
    logic [SW-1:0]    s_in;
    logic [RootW-1:0] rt_in;
    logic [RemW-1:0]  rm_in;
    logic [SW:0]      s_ext;
    logic [RemW+1:0]  trial_rem;
    logic [RemW+1:0]  trial_sub;
    if (i == 0) begin : g_first
      assign s_in  = s;
      assign rt_in = '0;
      assign rm_in = '0;
    end else begin : g_rest
      assign s_in  = s_r[i-1];
      assign rt_in = rt_r[i-1];
      assign rm_in = rm_r[i-1];
    end
    assign s_ext     = {1'b0, s_in};
    assign trial_rem = {rm_in, s_ext[SW-2*i -: 2]};
    assign trial_sub = {1'b0, rt_in, 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        s_r[i] <= s_in;
        if (trial_rem >= trial_sub) begin
          rm_r[i] <= RemW'(trial_rem - trial_sub);
          rt_r[i] <= {rt_in[RootW-2:0], 1'b1};
        end else begin
          rm_r[i] <= RemW'(trial_rem);
          rt_r[i] <= {rt_in[RootW-2:0], 1'b0};
        end
      end
    end
  end

  assign root = rt_r[SqStages-1];
endmodule

FILE: rtl/qmn_div.sv
// Pipelined restoring divider: (mag << 15) / len, one quotient bit per stage.
module qmn_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [qmn_pkg::MagW-1:0]  mag,
  input  logic [qmn_pkg::RootW-1:0] len,
  output logic [qmn_pkg::QW-1:0]    quot
);
  import qmn_pkg::*;

  logic [DivW-1:0]  rem_r [DivStages];
  logic [RootW-1:0] dv_r  [DivStages];
  logic [QW-1:0]    q_r   [DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    logic [DivW-1:0]  rem_in;
    logic [RootW-1:0] dv_in;
    logic [QW-1:0]    q_in;
    logic [DivW-1:0]  shifted;
    if (k == 0) begin : g_first
      assign rem_in = {mag, FracBits'(0)};
      assign dv_in  = len;
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = rem_r[k-1];
      assign dv_in  = dv_r[k-1];
      assign q_in   = q_r[k-1];
    end
    assign shifted = DivW'(dv_in) << (QW - 1 - k);
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k] <= dv_in;
        if (rem_in >= shifted) begin
          rem_r[k] <= rem_in - shifted;
          q_r[k]   <= q_in | (QW'(1) << (QW - 1 - k));
        end else begin
          rem_r[k] <= rem_in;
          q_r[k]   <= q_in;
        end
      end
    end
  end

  assign quot = q_r[DivStages-1];
endmodule

FILE: rtl/quaternion_multiply_normalize_top.sv
// Top level of the quaternion multiply and normalize pipeline.
// This block takes an item of two quaternions a and b on the operands channel,
// each component signed Q1.15, and returns one item on the result channel:
// the Hamilton product a*b, scaled to unit length in Q1.15, with clipped set
// when any component had to be saturated to the 16-bit range.
// A zero product gives all-zero components and clipped low.
// Both channels use valid/ready; an item moves when both are high.
// An accepted item reaches the result channel through 56 register stages:
// six front stages (partial products, product sum, magnitude, squares, two
// adds), 33 square root stages (one root bit per stage over a 65-bit sum
// of squares), 16 divider stages (one quotient bit per stage) and the
// output register.
// Throughput is one item per cycle while the receiver does not stall the pipeline, so items may arrive back to back.
// The whole pipeline advances together; when the receiver holds ready low
// while a result waits, every stage holds and operands.ready drops, so no
// item is lost or repeated. Empty stages do not block the pipeline.
// Synchronous reset clears the valid bits only; the block keeps no state
// across items.
module quaternion_multiply_normalize_top (
  input logic clk,
  input logic rst,
  qmn_in_if.sink    operands,
  qmn_out_if.source result
);
  import qmn_pkg::*;
  `include "quaternion_multiply_normalize_top_defines.svh"

  localparam int TailStages = SqStages + DivStages;

  logic               en;
  logic [Latency-1:0] vld;

  comp_t a_c [4];
  comp_t b_c [4];

  logic signed [ProdW-1:0] prod [4][4];
  logic signed [PW-1:0]    p    [4];
  mag_t                    m3   [4];
  logic [3:0]              sg3, sg4, sg5, sg6;
  mag_t                    m4   [4];
  mag_t                    m5   [4];
  mag_t                    m6   [4];
  logic [SW-1:0]           sq   [4];
  logic [SW-1:0]           pair [2];
  logic [SW-1:0]           s6;
  logic                    z6;

  mag_t       md   [SqStages][4];
  logic [3:0] sgd  [TailStages];
  logic       zd   [TailStages];

  root_t      len;
  quot_t      quot [4];
  comp_t      ov   [4];
  logic       clip_r;

  // The pipeline moves whenever the output register is free or being drained.
  assign en = !vld[Latency-1] || result.ready;
  assign operands.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Latency-2:0], operands.valid};
    end
  end

  assign a_c[0] = operands.a_w;
  assign a_c[1] = operands.a_x;
  assign a_c[2] = operands.a_y;
  assign a_c[3] = operands.a_z;
  assign b_c[0] = operands.b_w;
  assign b_c[1] = operands.b_x;
  assign b_c[2] = operands.b_y;
  assign b_c[3] = operands.b_z;

  // Front stages: all sixteen partial products, then the four product sums,
  // then magnitudes, squares and a two-level add of the squares.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod[i][j] <= a_c[i] * b_c[j];
        end
      end
      p[0] <= PW'(prod[0][0]) - PW'(prod[1][1]) - PW'(prod[2][2]) - PW'(prod[3][3]);
      p[1] <= PW'(prod[0][1]) + PW'(prod[1][0]) + PW'(prod[2][3]) - PW'(prod[3][2]);
      p[2] <= PW'(prod[0][2]) + PW'(prod[2][0]) + PW'(prod[3][1]) - PW'(prod[1][3]);
      p[3] <= PW'(prod[0][3]) + PW'(prod[3][0]) + PW'(prod[1][2]) - PW'(prod[2][1]);
      for (int i = 0; i < 4; i++) begin
        sg3[i] <= p[i][PW-1];
        m3[i]  <= p[i][PW-1] ? MagW'(-p[i]) : MagW'(p[i]);
        sq[i]  <= SW'(m3[i] * m3[i]);
        m4[i]  <= m3[i];
        m5[i]  <= m4[i];
        m6[i]  <= m5[i];
      end
      sg4     <= sg3;
      sg5     <= sg4;
      sg6     <= sg5;
      pair[0] <= sq[0] + sq[1];
      pair[1] <= sq[2] + sq[3];
      s6      <= pair[0] + pair[1];
      z6      <= (pair[0] + pair[1]) == '0;
    end
  end

  qmn_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .s    (s6),
    .root (len)
  );

  // Magnitudes wait out the square root; signs and the zero mark wait out
  // both the square root and the divider.
  always_ff @(posedge clk) begin
    if (en) begin
      md[0]  <= m6;
      sgd[0] <= sg6;
      zd[0]  <= z6;
      for (int k = 1; k < SqStages; k++) begin
        md[k] <= md[k-1];
      end
      for (int k = 1; k < TailStages; k++) begin
        sgd[k] <= sgd[k-1];
        zd[k]  <= zd[k-1];
      end
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    qmn_div u_div (
      .clk  (clk),
      .en   (en),
      .mag  (md[SqStages-1][i]),
      .len  (len),
      .quot (quot[i])
    );
  end

  // Output stage: apply the sign, saturate, and force zero for a zero product.
  always_ff @(posedge clk) begin
    logic [3:0] lane_clip;
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        lane_clip[i] = 1'b0;
        if (zd[TailStages-1]) begin
          ov[i] <= '0;
        end else if (sgd[TailStages-1][i]) begin
          if (quot[i] > QW'(32768)) begin
            ov[i]        <= comp_t'(-32768);
            lane_clip[i] = 1'b1;
          end else begin
            ov[i] <= comp_t'(-quot[i]);
          end
        end else begin
          if (quot[i] > QW'(32767)) begin
            ov[i]        <= comp_t'(32767);
            lane_clip[i] = 1'b1;
          end else begin
            ov[i] <= comp_t'(quot[i]);
          end
        end
      end
      clip_r <= !zd[TailStages-1] && (lane_clip != '0);
    end
  end

  assign result.valid   = vld[Latency-1];
  assign result.out_w   = ov[0];
  assign result.out_x   = ov[1];
  assign result.out_y   = ov[2];
  assign result.out_z   = ov[3];
  assign result.clipped = clip_r;

  `QMN_ASSERT_NEXT(a_accept_enters, clk, rst, operands.valid && operands.ready, vld[0])
  `QMN_ASSERT_NEXT(a_stall_holds, clk, rst, !en, $stable(vld))
  `QMN_ASSERT_NOW(a_clip_saturates, clk, rst, result.valid && result.clipped,
    result.out_w == 16'sh7fff || result.out_w == 16'sh8000 ||
    result.out_x == 16'sh7fff || result.out_x == 16'sh8000 ||
    result.out_y == 16'sh7fff || result.out_y == 16'sh8000 ||
    result.out_z == 16'sh7fff || result.out_z == 16'sh8000)
endmodule
